### rtl/sparse_tile_rank_lookup_defines.svh
// ----------------------------------------------------------------------------
// Sparse tile rank lookup assertion macros
// Shared assertion forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TILE_RANK_LOOKUP_DEFINES_SVH
`define SPARSE_TILE_RANK_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stl assertion failed");

// Next-cycle implication, checked outside reset.
`define STL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stl assertion failed");

`endif

### rtl/stl_pkg.sv
// ----------------------------------------------------------------------------
// Sparse tile rank lookup package
// Shared constants, command codes, queue entry and sequencer state types.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 256;
  localparam int MAX_ENTRIES = 16384;

  localparam int PRES_DEPTH = (MAX_COLS * MAX_ROWS + 7) / 8;
  localparam int PRES_AW    = $clog2(PRES_DEPTH);
  localparam int ROW_AW     = $clog2(MAX_ROWS);
  localparam int COL_AW     = $clog2(MAX_COLS);
  localparam int ENT_AW     = $clog2(MAX_ENTRIES);
  localparam int POS_W      = PRES_AW + 3;
  localparam int COL_W      = COL_AW + 1;
  localparam int CNT_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD_BITMAP = 2'd0,
    CMD_LOAD_PREFIX = 2'd1,
    CMD_LOAD_ENTRY  = 2'd2,
    CMD_LOOKUP      = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_WIDTH_TILES   = 3'd2,
    REG_HEIGHT_TILES  = 3'd3,
    REG_PRESENT_COUNT = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_EWAIT,
    ST_EDONE
  } back_state_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [13:0]      load_addr;
    logic [14:0]      load_value;
    logic [31:0]      offset;
    logic [15:0]      length;
    logic [15:0]      flags;
    logic             in_win;
    logic [ROW_AW-1:0] ly;
    logic [POS_W-1:0] row_start;
    logic [POS_W-1:0] bit_pos;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t data;
  } q_head_t;

endpackage

### rtl/stl_ifs.sv
// ----------------------------------------------------------------------------
// Sparse tile rank lookup channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface stl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [13:0] load_addr;
  logic [14:0] load_value;
  logic [31:0] entry_offset;
  logic [15:0] entry_length;
  logic [15:0] entry_flags;
  logic signed [31:0] tile_x;
  logic signed [31:0] tile_y;
  modport source (output valid, cmd, load_addr, load_value, entry_offset, entry_length,
                  entry_flags, tile_x, tile_y, input ready);
  modport sink (input valid, cmd, load_addr, load_value, entry_offset, entry_length,
                entry_flags, tile_x, tile_y, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] tile_offset;
  logic [15:0] tile_length;
  logic [15:0] tile_flags;
  modport source (output valid, found, tile_offset, tile_length, tile_flags, input ready);
  modport sink (input valid, found, tile_offset, tile_length, tile_flags, output ready);
endinterface

interface stl_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [30:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/stl_front.sv
// ----------------------------------------------------------------------------
// Sparse tile rank lookup front end
// Accepts requests, checks the window and computes bit positions for lookups.
// ----------------------------------------------------------------------------
module stl_front import stl_pkg::*; (
  stl_in_if.sink           in_ch,
  input  logic [30:0]      origin_x,
  input  logic [30:0]      origin_y,
  input  logic [8:0]       width_tiles,
  input  logic [8:0]       height_tiles,
  input  logic             q_full,
  output logic             q_push,
  output q_entry_t         q_wdata
);

  logic [COL_W-1:0] nx;
  logic [COL_W-1:0] ny;
  logic [32:0]      dx;
  logic [32:0]      dy;
  logic             x_ok;
  logic             y_ok;
  logic [POS_W-1:0] row_start;

  always_comb begin
    nx = (width_tiles > 9'(MAX_COLS)) ? COL_W'(MAX_COLS) : COL_W'(width_tiles);
    ny = (height_tiles > 9'(MAX_ROWS)) ? COL_W'(MAX_ROWS) : COL_W'(height_tiles);
    dx = {in_ch.tile_x[31], in_ch.tile_x} - {2'b00, origin_x};
    dy = {in_ch.tile_y[31], in_ch.tile_y} - {2'b00, origin_y};
    x_ok = !dx[32] && (dx[31:0] < 32'(nx));
    y_ok = !dy[32] && (dy[31:0] < 32'(ny));
    row_start = POS_W'(dy[ROW_AW-1:0] * nx);
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.cmd        = cmd_t'(in_ch.cmd);
    q_wdata.load_addr  = in_ch.load_addr;
    q_wdata.load_value = in_ch.load_value;
    q_wdata.offset     = in_ch.entry_offset;
    q_wdata.length     = in_ch.entry_length;
    q_wdata.flags      = in_ch.entry_flags;
    q_wdata.in_win     = x_ok && y_ok;
    q_wdata.ly         = dy[ROW_AW-1:0];
    q_wdata.row_start  = row_start;
    q_wdata.bit_pos    = row_start + POS_W'(dx[COL_AW-1:0]);
  end

endmodule

### rtl/stl_fifo.sv
// ----------------------------------------------------------------------------
// Sparse tile rank lookup request queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module stl_fifo import stl_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  q_entry_t     wdata,
  input  logic         pop,
  output logic         full,
  output q_head_t      head,
  output logic [QAW:0] count
);

  q_entry_t         mem_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt;
  logic [QAW-1:0]   rp_r, rp_nxt;
  logic [QAW:0]     cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign full       = (cnt_r == (QAW+1)'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.data  = mem_r[rp_r];
  assign count      = cnt_r;

endmodule

### rtl/stl_back.sv
// ----------------------------------------------------------------------------
// Sparse tile rank lookup back end
// Performs loads into the stores and runs the rank scan and entry read.
// ----------------------------------------------------------------------------
module stl_back import stl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] present_count,
  input  q_head_t          head,
  output logic             pop,
  stl_out_if.source        out_ch
);

  logic [7:0]  pres_mem [PRES_DEPTH];
  logic [14:0] pfx_mem  [MAX_ROWS];
  logic [63:0] ent_mem  [MAX_ENTRIES];

  logic [7:0]  pres_dout_r;
  logic [14:0] pfx_dout_r;
  logic [63:0] ent_dout_r;

  back_state_t       state_r, state_nxt;
  logic [PRES_AW-1:0] cnt_r, cnt_nxt;
  logic [COL_AW-1:0] acc_r, acc_nxt;
  logic              hit_r, hit_nxt;
  logic [ROW_AW-1:0] ly_r, ly_nxt;
  logic [POS_W-1:0]  row_start_r, row_start_nxt;
  logic [POS_W-1:0]  bit_pos_r, bit_pos_nxt;
  logic [ENT_AW-1:0] rank_r, rank_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       offset_r, offset_nxt;
  logic [15:0]       length_r, length_nxt;
  logic [15:0]       flags_r, flags_nxt;

  logic pres_we, pfx_we, ent_we;
  logic [3:0]  pcnt;
  logic [POS_W-1:0] pos;
  logic [15:0] rank;

  always_comb begin
    pcnt = '0;
    for (int k = 0; k < 8; k++) begin
      pos = {cnt_r, 3'(k)};
      if (pres_dout_r[7-k] && (pos >= row_start_r) && (pos < bit_pos_r)) begin
        pcnt = pcnt + 4'd1;
      end
    end
    rank = 16'(pfx_dout_r) + 16'(acc_r);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    hit_nxt       = hit_r;
    ly_nxt        = ly_r;
    row_start_nxt = row_start_r;
    bit_pos_nxt   = bit_pos_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    length_nxt    = length_r;
    flags_nxt     = flags_r;
    pop           = 1'b0;
    pres_we       = 1'b0;
    pfx_we        = 1'b0;
    ent_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.data.cmd == CMD_LOOKUP) begin
            if (!out_valid_r) begin
              pop = 1'b1;
              if (!head.data.in_win) begin
                out_valid_nxt = 1'b1;
                found_nxt     = 1'b0;
                offset_nxt    = '0;
                length_nxt    = '0;
                flags_nxt     = '0;
              end else begin
                ly_nxt        = head.data.ly;
                row_start_nxt = head.data.row_start;
                bit_pos_nxt   = head.data.bit_pos;
                cnt_nxt       = head.data.row_start[POS_W-1:3];
                acc_nxt       = '0;
                state_nxt     = ST_SCAN;
              end
            end
          end else begin
            pop     = 1'b1;
            pres_we = (head.data.cmd == CMD_LOAD_BITMAP) &&
                      (32'(head.data.load_addr) < 32'(PRES_DEPTH));
            pfx_we  = (head.data.cmd == CMD_LOAD_PREFIX) &&
                      (32'(head.data.load_addr) < 32'(MAX_ROWS));
            ent_we  = (head.data.cmd == CMD_LOAD_ENTRY) &&
                      (32'(head.data.load_addr) < 32'(MAX_ENTRIES));
          end
        end
      end
      ST_SCAN: begin
        acc_nxt = acc_r + COL_AW'(pcnt);
        if (cnt_r == bit_pos_r[POS_W-1:3]) begin
          hit_nxt   = pres_dout_r[3'd7 - bit_pos_r[2:0]];
          state_nxt = ST_CHECK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CHECK: begin
        if (hit_r && (rank < {1'b0, present_count}) && (rank < 16'(MAX_ENTRIES))) begin
          rank_nxt  = rank[ENT_AW-1:0];
          state_nxt = ST_EWAIT;
        end else begin
          out_valid_nxt = 1'b1;
          found_nxt     = 1'b0;
          offset_nxt    = '0;
          length_nxt    = '0;
          flags_nxt     = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_EWAIT: begin
        state_nxt = ST_EDONE;
      end
      ST_EDONE: begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b1;
        offset_nxt    = ent_dout_r[31:0];
        length_nxt    = ent_dout_r[47:32];
        flags_nxt     = ent_dout_r[63:48];
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    acc_r       <= acc_nxt;
    hit_r       <= hit_nxt;
    ly_r        <= ly_nxt;
    row_start_r <= row_start_nxt;
    bit_pos_r   <= bit_pos_nxt;
    rank_r      <= rank_nxt;
    found_r     <= found_nxt;
    offset_r    <= offset_nxt;
    length_r    <= length_nxt;
    flags_r     <= flags_nxt;
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[head.data.load_addr[PRES_AW-1:0]] <= head.data.load_value[7:0];
    end
    pres_dout_r <= pres_mem[cnt_nxt];
  end

  always_ff @(posedge clk) begin
    if (pfx_we) begin
      pfx_mem[head.data.load_addr[ROW_AW-1:0]] <= head.data.load_value;
    end
    pfx_dout_r <= pfx_mem[ly_r];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[head.data.load_addr[ENT_AW-1:0]] <=
        {head.data.flags, head.data.length, head.data.offset};
    end
    ent_dout_r <= ent_mem[rank_r];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.tile_offset = offset_r;
  assign out_ch.tile_length = length_r;
  assign out_ch.tile_flags  = flags_r;

endmodule

### rtl/sparse_tile_rank_lookup.sv
// Sequence: a load is written into its store once it reaches the queue head and the back
// end is idle; a lookup outside the window yields a miss result directly, else the back end
// scans the bitmap bytes spanned from the row start to the tile (1 to 33), checks the rank
// and, when the tile is found, reads the entry store before the result is presented.
// Throughput: one lookup at a time; a lookup waits while the scan runs or a result is held.
// Reset: synchronous active-low; resets control, queue and config, not data or stores.
// ----------------------------------------------------------------------------
// Sparse tile rank lookup top level
// Configuration registers, front end, request queue and back end.
// ----------------------------------------------------------------------------
`include "sparse_tile_rank_lookup_defines.svh"

module sparse_tile_rank_lookup import stl_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  stl_in_if.sink     in_ch,
  stl_out_if.source  out_ch,
  stl_cfg_if.sink    cfg_ch
);

  logic [30:0]      origin_x_r;
  logic [30:0]      origin_y_r;
  logic [8:0]       width_r;
  logic [8:0]       height_r;
  logic [CNT_W-1:0] pcount_r;

  logic         q_full;
  logic         q_push;
  q_entry_t     q_wdata;
  logic         q_pop;
  q_head_t      q_head;
  logic [QAW:0] q_count;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= 9'd1;
      height_r   <= 9'd1;
      pcount_r   <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ORIGIN_X:      origin_x_r <= cfg_ch.data;
        REG_ORIGIN_Y:      origin_y_r <= cfg_ch.data;
        REG_WIDTH_TILES:   width_r    <= cfg_ch.data[8:0];
        REG_HEIGHT_TILES:  height_r   <= cfg_ch.data[8:0];
        REG_PRESENT_COUNT: pcount_r   <= cfg_ch.data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  stl_front u_front (
    .in_ch        (in_ch),
    .origin_x     (origin_x_r),
    .origin_y     (origin_y_r),
    .width_tiles  (width_r),
    .height_tiles (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  stl_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .head  (q_head),
    .count (q_count)
  );

  stl_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .present_count (pcount_r),
    .head          (q_head),
    .pop           (q_pop),
    .out_ch        (out_ch)
  );

  `STL_ASSERT_NOW(a_miss_zero, out_ch.valid && !out_ch.found,
    out_ch.tile_offset == 32'd0 && out_ch.tile_length == 16'd0 && out_ch.tile_flags == 16'd0)
  `STL_ASSERT_NOW(a_q_bound, 1'b1, q_count <= (QAW+1)'(QDEPTH))
  `STL_ASSERT_NEXT(a_push_fills, q_push && !q_pop, q_count != '0)

endmodule
